// ===== src/y86s_pkg.sv =====
package y86s_pkg;

	localparam int MEM_BYTES = 4096;
	localparam int MEM_AW = $clog2(MEM_BYTES);
	localparam logic [32:0] MEM_LIMIT = 33'(MEM_BYTES);

	// run status
	localparam logic [1:0] ST_OK  = 2'd0;
	localparam logic [1:0] ST_HLT = 2'd1;
	localparam logic [1:0] ST_ADR = 2'd2;
	localparam logic [1:0] ST_INS = 2'd3;

	// request modes
	localparam logic [1:0] MD_WR  = 2'd0;
	localparam logic [1:0] MD_RD  = 2'd1;
	localparam logic [1:0] MD_REG = 2'd2;
	localparam logic [1:0] MD_EXE = 2'd3;

	// instruction codes
	localparam logic [3:0] I_HALT  = 4'h0;
	localparam logic [3:0] I_NOP   = 4'h1;
	localparam logic [3:0] I_CMOV  = 4'h2;
	localparam logic [3:0] I_IRMOV = 4'h3;
	localparam logic [3:0] I_RMMOV = 4'h4;
	localparam logic [3:0] I_MRMOV = 4'h5;
	localparam logic [3:0] I_OPL   = 4'h6;
	localparam logic [3:0] I_JXX   = 4'h7;
	localparam logic [3:0] I_CALL  = 4'h8;
	localparam logic [3:0] I_RET   = 4'h9;
	localparam logic [3:0] I_PUSH  = 4'hA;
	localparam logic [3:0] I_POP   = 4'hB;

	// alu functions
	localparam logic [3:0] A_ADD = 4'h0;
	localparam logic [3:0] A_SUB = 4'h1;
	localparam logic [3:0] A_AND = 4'h2;
	localparam logic [3:0] A_XOR = 4'h3;

	localparam logic [3:0] FN_CMAX  = 4'h6;
	localparam logic [3:0] FN_AMAX  = 4'h3;
	localparam logic [2:0] FLAGS_RESET = 3'b100;
	localparam logic [2:0] REG_SP = 3'd4;

	typedef struct packed {
		logic [1:0]  status;
		logic [31:0] pc;
		logic [2:0]  flags;
		logic [31:0] rv;
	} y86s_result_t;

	// flags: zero bit 2, sign bit 1, overflow bit 0
	function automatic logic cond_true(input logic [3:0] fn, input logic [2:0] fl);
		logic lt;
		logic res;
		lt = fl[1] ^ fl[0];
		case (fn)
			4'h0: res = 1'b1;
			4'h1: res = lt | fl[2];
			4'h2: res = lt;
			4'h3: res = fl[2];
			4'h4: res = ~fl[2];
			4'h5: res = ~lt;
			4'h6: res = ~lt & ~fl[2];
			default: res = 1'b0;
		endcase
		return res;
	endfunction

	function automatic logic word_ok(input logic [31:0] a);
		return ({1'b0, a} + 33'd4) <= MEM_LIMIT;
	endfunction

endpackage

// ===== src/y86s_ram.sv =====
module y86s_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule

// ===== src/y86s_core.sv =====
module y86s_core (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  start,
	input  logic [1:0]            mode,
	input  logic [11:0]           address,
	input  logic [7:0]            data,
	output logic                  ready,
	output logic                  res_valid,
	input  logic                  res_take,
	output y86s_pkg::y86s_result_t res
);
	import y86s_pkg::*;

	localparam logic [3:0] S_CLR  = 4'd0;
	localparam logic [3:0] S_IDLE = 4'd1;
	localparam logic [3:0] S_MRD  = 4'd2;
	localparam logic [3:0] S_RRD  = 4'd3;
	localparam logic [3:0] S_F1   = 4'd4;
	localparam logic [3:0] S_FET  = 4'd5;
	localparam logic [3:0] S_RA   = 4'd6;
	localparam logic [3:0] S_RB   = 4'd7;
	localparam logic [3:0] S_SP   = 4'd8;
	localparam logic [3:0] S_EX   = 4'd9;
	localparam logic [3:0] S_LD   = 4'd10;
	localparam logic [3:0] S_LDW  = 4'd11;
	localparam logic [3:0] S_POP  = 4'd12;
	localparam logic [3:0] S_ST   = 4'd13;
	localparam logic [3:0] S_DONE = 4'd14;

	logic [3:0]        state_q;
	logic [MEM_AW-1:0] clr_q;
	logic [31:0]       pc_q;
	logic [2:0]        flags_q;
	logic [1:0]        status_q;
	logic [31:0]       rv_q;
	logic [3:0]        icode_q;
	logic [3:0]        fn_q;
	logic [7:0]        ib_q [5];
	logic [31:0]       base_q;
	logic [2:0]        cnt_q;
	logic [2:0]        tot_q;
	logic [2:0]        rx_q;
	logic              rvld_q;
	logic [31:0]       va_q;
	logic [31:0]       vb_q;
	logic [31:0]       sp_q;
	logic [3:0]        ra_q;
	logic [31:0]       next_q;
	logic [31:0]       st_data_q;
	logic [MEM_AW-1:0] st_addr_q;
	logic [31:0]       req_addr_q;

	// memory and register file ports
	logic              m_we;
	logic [MEM_AW-1:0] m_waddr;
	logic [7:0]        m_wdata;
	logic [MEM_AW-1:0] m_raddr;
	logic [7:0]        m_rdata;
	logic              r_we;
	logic [2:0]        r_waddr;
	logic [31:0]       r_wdata;
	logic [2:0]        r_raddr;
	logic [31:0]       r_rdata;

	logic [31:0] req_a32;
	logic        req_in_mem;
	logic        eng;
	logic        rd_issue;
	logic        eng_done;
	logic [31:0] eng_addr;
	logic [31:0] st_a;
	logic        has_regs;
	logic        has_imm;
	logic [2:0]  len;
	logic        bad_fn;
	logic [3:0]  f_icode;
	logic [3:0]  f_fn;
	logic [3:0]  ra_c;
	logic [3:0]  rb_c;
	logic [31:0] imm;
	logic [31:0] word;
	logic        cond;
	logic [31:0] ex_addr;
	logic        ex_ok;
	logic [31:0] alu_r;
	logic        alu_ov;
	logic [2:0]  alu_flags;

	y86s_ram #(.WIDTH(8), .DEPTH(MEM_BYTES)) u_mem (
		.clk(clk), .we(m_we), .waddr(m_waddr), .wdata(m_wdata),
		.raddr(m_raddr), .rdata(m_rdata)
	);

	y86s_ram #(.WIDTH(32), .DEPTH(8)) u_regs (
		.clk(clk), .we(r_we), .waddr(r_waddr), .wdata(r_wdata),
		.raddr(r_raddr), .rdata(r_rdata)
	);

	assign req_a32 = {20'd0, address};
	assign req_in_mem = {1'b0, req_a32} < MEM_LIMIT;

	// byte read engine: issue at base + cnt, collect the byte on the next cycle
	assign eng = (state_q == S_FET) || (state_q == S_LD);
	assign rd_issue = eng && (cnt_q != tot_q);
	assign eng_done = eng && !rd_issue && !rvld_q;
	assign eng_addr = base_q + {29'd0, cnt_q};
	assign st_a = {{(32-MEM_AW){1'b0}}, st_addr_q} + {29'd0, cnt_q};

	assign f_icode = m_rdata[7:4];
	assign f_fn = m_rdata[3:0];
	assign has_regs = ((f_icode >= I_CMOV) && (f_icode <= I_OPL)) || (f_icode >= I_PUSH);
	assign has_imm = (f_icode >= I_IRMOV) && (f_icode <= I_CALL) && (f_icode != I_OPL);
	assign len = 3'd1 + (has_regs ? 3'd1 : 3'd0) + (has_imm ? 3'd4 : 3'd0);
	assign bad_fn = (((f_icode == I_CMOV) || (f_icode == I_JXX)) && (f_fn > FN_CMAX))
		|| ((f_icode == I_OPL) && (f_fn > FN_AMAX));

	logic cur_regs;
	assign cur_regs = ((icode_q >= I_CMOV) && (icode_q <= I_OPL)) || (icode_q >= I_PUSH);
	assign ra_c = cur_regs ? ib_q[0][7:4] : 4'hF;
	assign rb_c = cur_regs ? ib_q[0][3:0] : 4'hF;
	assign imm = cur_regs ? {ib_q[4], ib_q[3], ib_q[2], ib_q[1]}
		: {ib_q[3], ib_q[2], ib_q[1], ib_q[0]};
	assign word = {ib_q[3], ib_q[2], ib_q[1], ib_q[0]};
	assign cond = cond_true(fn_q, flags_q);

	always_comb begin
		case (icode_q)
			I_RMMOV, I_MRMOV: ex_addr = vb_q + imm;
			I_CALL, I_PUSH:   ex_addr = r_rdata - 32'd4;
			default:          ex_addr = r_rdata;
		endcase
	end
	assign ex_ok = word_ok(ex_addr);

	always_comb begin
		case (fn_q)
			A_ADD:   alu_r = vb_q + va_q;
			A_SUB:   alu_r = vb_q - va_q;
			A_AND:   alu_r = vb_q & va_q;
			default: alu_r = vb_q ^ va_q;
		endcase
		case (fn_q)
			A_ADD:   alu_ov = (va_q[31] == vb_q[31]) && (alu_r[31] != vb_q[31]);
			A_SUB:   alu_ov = (va_q[31] != vb_q[31]) && (alu_r[31] != vb_q[31]);
			default: alu_ov = 1'b0;
		endcase
		alu_flags = {alu_r == 32'd0, alu_r[31], alu_ov};
	end

	// memory port steering
	always_comb begin
		m_we = 1'b0;
		m_waddr = clr_q;
		m_wdata = 8'd0;
		m_raddr = pc_q[MEM_AW-1:0];
		unique case (state_q)
			S_CLR: m_we = 1'b1;
			S_IDLE: begin
				if (mode == MD_RD) begin
					m_raddr = req_a32[MEM_AW-1:0];
				end
				if (start && (mode == MD_WR) && req_in_mem) begin
					m_we = 1'b1;
					m_waddr = req_a32[MEM_AW-1:0];
					m_wdata = data;
				end
			end
			S_ST: begin
				m_we = 1'b1;
				m_waddr = st_a[MEM_AW-1:0];
				m_wdata = st_data_q[8*cnt_q[1:0] +: 8];
			end
			S_FET, S_LD: m_raddr = eng_addr[MEM_AW-1:0];
			default: m_raddr = pc_q[MEM_AW-1:0];
		endcase
	end

	// register file port steering
	always_comb begin
		r_we = 1'b0;
		r_waddr = clr_q[2:0];
		r_wdata = 32'd0;
		r_raddr = 3'd0;
		unique case (state_q)
			S_CLR: r_we = (clr_q < MEM_AW'(8));
			S_IDLE: r_raddr = address[2:0];
			S_RA: r_raddr = ra_c[2:0];
			S_RB: r_raddr = rb_c[2:0];
			S_SP: r_raddr = REG_SP;
			S_EX: begin
				r_waddr = rb_c[2:0];
				unique case (icode_q)
					I_CMOV: begin
						r_we = cond && !rb_c[3];
						r_wdata = va_q;
					end
					I_IRMOV: begin
						r_we = !rb_c[3];
						r_wdata = imm;
					end
					I_OPL: begin
						r_we = !rb_c[3];
						r_wdata = alu_r;
					end
					I_CALL, I_PUSH: begin
						r_we = ex_ok;
						r_waddr = REG_SP;
						r_wdata = ex_addr;
					end
					default: r_we = 1'b0;
				endcase
			end
			S_LDW: begin
				if (icode_q == I_MRMOV) begin
					r_we = !ra_q[3];
					r_waddr = ra_q[2:0];
					r_wdata = word;
				end else begin
					r_we = 1'b1;
					r_waddr = REG_SP;
					r_wdata = sp_q + 32'd4;
				end
			end
			S_POP: begin
				r_we = !ra_q[3];
				r_waddr = ra_q[2:0];
				r_wdata = st_data_q;
			end
			default: r_raddr = 3'd0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLR;
			clr_q <= '0;
			pc_q <= 32'd0;
			flags_q <= FLAGS_RESET;
			status_q <= ST_OK;
			rvld_q <= 1'b0;
			cnt_q <= 3'd0;
			tot_q <= 3'd0;
			rx_q <= 3'd0;
		end else begin
			rvld_q <= rd_issue;
			if (rd_issue) begin
				cnt_q <= cnt_q + 3'd1;
			end
			if (rvld_q) begin
				ib_q[rx_q] <= m_rdata;
				rx_q <= rx_q + 3'd1;
			end
			unique case (state_q)
				S_CLR: begin
					clr_q <= clr_q + 1'b1;
					if (clr_q == MEM_AW'(MEM_BYTES - 1)) begin
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					if (start) begin
						rv_q <= 32'd0;
						req_addr_q <= req_a32;
						unique case (mode)
							MD_WR: state_q <= S_DONE;
							MD_RD: state_q <= S_MRD;
							MD_REG: state_q <= S_RRD;
							default: begin
								if (status_q != ST_OK) begin
									state_q <= S_DONE;
								end else if ({1'b0, pc_q} >= MEM_LIMIT) begin
									status_q <= ST_ADR;
									state_q <= S_DONE;
								end else begin
									state_q <= S_F1;
								end
							end
						endcase
					end
				end
				S_MRD: begin
					rv_q <= ({1'b0, req_addr_q} < MEM_LIMIT) ? {24'd0, m_rdata} : 32'd0;
					state_q <= S_DONE;
				end
				S_RRD: begin
					rv_q <= (req_addr_q < 32'd8) ? r_rdata : 32'd0;
					state_q <= S_DONE;
				end
				S_F1: begin
					icode_q <= f_icode;
					fn_q <= f_fn;
					next_q <= pc_q + {29'd0, len};
					base_q <= pc_q + 32'd1;
					cnt_q <= 3'd0;
					tot_q <= len - 3'd1;
					rx_q <= 3'd0;
					if (f_icode > I_POP) begin
						status_q <= ST_INS;
						state_q <= S_DONE;
					end else if (({1'b0, pc_q} + {30'd0, len}) > MEM_LIMIT) begin
						status_q <= ST_ADR;
						state_q <= S_DONE;
					end else if (bad_fn) begin
						status_q <= ST_INS;
						state_q <= S_DONE;
					end else begin
						state_q <= S_FET;
					end
				end
				S_FET: begin
					if (eng_done) begin
						state_q <= S_RA;
					end
				end
				S_RA: begin
					ra_q <= ra_c;
					state_q <= S_RB;
				end
				S_RB: begin
					va_q <= ra_q[3] ? 32'd0 : r_rdata;
					state_q <= S_SP;
				end
				S_SP: begin
					vb_q <= rb_c[3] ? 32'd0 : r_rdata;
					state_q <= S_EX;
				end
				S_EX: begin
					sp_q <= r_rdata;
					st_addr_q <= ex_addr[MEM_AW-1:0];
					base_q <= ex_addr;
					cnt_q <= 3'd0;
					tot_q <= 3'd4;
					rx_q <= 3'd0;
					state_q <= S_DONE;
					unique case (icode_q)
						I_HALT: status_q <= ST_HLT;
						I_NOP, I_CMOV, I_IRMOV: pc_q <= next_q;
						I_OPL: begin
							flags_q <= alu_flags;
							pc_q <= next_q;
						end
						I_JXX: pc_q <= cond ? imm : next_q;
						I_RMMOV, I_PUSH, I_CALL: begin
							if (!ex_ok) begin
								status_q <= ST_ADR;
							end else begin
								st_data_q <= (icode_q == I_CALL) ? next_q : va_q;
								pc_q <= (icode_q == I_CALL) ? imm : next_q;
								state_q <= S_ST;
							end
						end
						I_MRMOV, I_RET, I_POP: begin
							if (!ex_ok) begin
								status_q <= ST_ADR;
							end else begin
								state_q <= S_LD;
							end
						end
						default: state_q <= S_DONE;
					endcase
				end
				S_LD: begin
					if (eng_done) begin
						state_q <= S_LDW;
					end
				end
				S_LDW: begin
					st_data_q <= word;
					pc_q <= (icode_q == I_RET) ? word : next_q;
					state_q <= (icode_q == I_POP) ? S_POP : S_DONE;
				end
				S_POP: state_q <= S_DONE;
				S_ST: begin
					cnt_q <= cnt_q + 3'd1;
					if (cnt_q == 3'd3) begin
						state_q <= S_DONE;
					end
				end
				S_DONE: begin
					if (res_take) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign ready = (state_q == S_IDLE);
	assign res_valid = (state_q == S_DONE);
	assign res = '{status: status_q, pc: pc_q, flags: flags_q, rv: rv_q};
endmodule

// ===== src/y86_instruction_step_top.sv =====
// Y86-32 instruction step engine. Each request writes a memory byte, reads a
// memory byte, reads a register, or executes one instruction, and yields one
// response carrying the run status, the pc, the condition flags and the value
// read. State lives in a byte-wide 4096-entry memory and an 8-entry register
// file, each with a single read and a single write port. After reset the block
// clears the memory (and register file) before it raises req_ready. An
// instruction is executed as a byte-serial fetch of up to six instruction
// bytes, three register-file reads, and a byte-by-byte access of the four
// bytes of any data word load or store. A fault found at fetch, or a step
// while stopped, ends the step without execution. A finished response sits
// in an output register so the next request can be taken while it waits.
module y86_instruction_step_top (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        req_valid,
	output logic        req_ready,
	input  logic [1:0]  mode,
	input  logic [11:0] address,
	input  logic [7:0]  data,
	output logic        rsp_valid,
	input  logic        rsp_ready,
	output logic [1:0]  status,
	output logic [31:0] program_counter,
	output logic [2:0]  cond_flags,
	output logic [31:0] read_value
);
	import y86s_pkg::*;

	logic         core_ready;
	logic         res_valid;
	logic         res_take;
	y86s_result_t res;
	y86s_result_t out_q;
	logic         out_valid_q;

	// request transfer
	assign req_ready = core_ready;

	y86s_core u_core (
		.clk(clk), .arst_n(arst_n),
		.start(req_valid && core_ready),
		.mode(mode), .address(address), .data(data),
		.ready(core_ready),
		.res_valid(res_valid), .res_take(res_take), .res(res)
	);

	// output register frees when empty or its transfer completes
	assign res_take = !out_valid_q || rsp_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			out_q.status <= ST_OK;
		end else begin
			if (res_valid && res_take) begin
				out_valid_q <= 1'b1;
				out_q <= res;
			end else if (rsp_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign rsp_valid = out_valid_q;
	assign status = out_q.status;
	assign program_counter = out_q.pc;
	assign cond_flags = out_q.flags;
	assign read_value = out_q.rv;

	// stop status is sticky across responses
	a_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		(status != ST_OK) |=> (status != ST_OK))
		else $error("stop status cleared");

	// engine never takes a request while holding a result
	a_excl: assert property (@(posedge clk) disable iff (!arst_n)
		!(core_ready && res_valid))
		else $error("ready while result pending");

	// handing off a result returns the engine to idle
	a_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid && res_take) |=> core_ready)
		else $error("engine not idle after result transfer");
endmodule
